// ===== rtl/joint_torque_to_drive_word_top_defines.svh =====
// Assertion macros used by the top level of the drive word converter.
`ifndef JOINT_TORQUE_TO_DRIVE_WORD_TOP_DEFINES_SVH
`define JOINT_TORQUE_TO_DRIVE_WORD_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JTDW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define JTDW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jtdw_pkg.sv =====
// Package with types, operation codes and helpers of the drive word converter.
`timescale 1ns / 1ps
package jtdw_pkg;

	localparam int ACTUATORS_DEF      = 7;
	localparam int JOINTS_DEF         = 6;
	localparam int DRIVE_CHANNELS_DEF = 8;
	localparam int DAC_BITS_DEF       = 16;
	localparam int FRAC_BITS_DEF      = 16;

	// Queue between front and back
	localparam int Q_DEPTH = 4;

	// Fixed field widths
	localparam int WORD_W   = 32;
	localparam int OP_W     = 3;
	localparam int OP_ADDR_W = 6;

	// Classified operations
	localparam logic [OP_W-1:0] OP_CPL     = 3'd0;
	localparam logic [OP_W-1:0] OP_AMPS    = 3'd1;
	localparam logic [OP_W-1:0] OP_LIM     = 3'd2;
	localparam logic [OP_W-1:0] OP_BSC     = 3'd3;
	localparam logic [OP_W-1:0] OP_BOF     = 3'd4;
	localparam logic [OP_W-1:0] OP_TRQ     = 3'd5;
	localparam logic [OP_W-1:0] OP_TRQ_RUN = 3'd6;
	localparam logic [OP_W-1:0] OP_RUN     = 3'd7;

	// Calibration table selects
	localparam logic [2:0] SEL_CPL  = 3'd0;
	localparam logic [2:0] SEL_AMPS = 3'd1;
	localparam logic [2:0] SEL_LIM  = 3'd2;
	localparam logic [2:0] SEL_BSC  = 3'd3;
	localparam logic [2:0] SEL_BOF  = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]      code;
		logic [OP_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]    value;
	} jtdw_op_t;

	// Saturate a signed 64-bit value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7fff_ffff;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi)
			return 32'sh7fff_ffff;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

// ===== rtl/jtdw_front.sv =====
// Front end: accepts command items, classifies them and pushes operations.
`timescale 1ns / 1ps
module jtdw_front import jtdw_pkg::*; #(
	parameter int ACTUATORS = ACTUATORS_DEF,
	parameter int JOINTS    = JOINTS_DEF
) (
	input  logic              start,
	input  logic              q_full,
	input  logic              mode,
	input  logic [2:0]        table_sel,
	input  logic [2:0]        actuator_index,
	input  logic [2:0]        joint_index,
	input  logic [WORD_W-1:0] value,
	input  logic              last,
	output logic              push,
	output jtdw_op_t          op
);

	logic act_ok;
	logic jnt_ok;
	logic keep;

	assign act_ok = (int'(actuator_index) < ACTUATORS);
	assign jnt_ok = (int'(joint_index) < JOINTS);

	// Classify the transfer into one back-end operation, or drop it
	always_comb begin
		keep       = 1'b0;
		op.code    = OP_RUN;
		op.addr    = '0;
		op.value   = value;
		if (!mode) begin
			op.addr = OP_ADDR_W'(actuator_index);
			case (table_sel)
				SEL_CPL: begin
					keep    = act_ok && jnt_ok;
					op.code = OP_CPL;
					op.addr = OP_ADDR_W'(int'(actuator_index) * JOINTS + int'(joint_index));
				end
				SEL_AMPS: begin
					keep    = act_ok;
					op.code = OP_AMPS;
				end
				SEL_LIM: begin
					keep    = act_ok;
					op.code = OP_LIM;
				end
				SEL_BSC: begin
					keep    = act_ok;
					op.code = OP_BSC;
				end
				SEL_BOF: begin
					keep    = act_ok;
					op.code = OP_BOF;
				end
				default: keep = 1'b0;
			endcase
		end else begin
			op.addr = OP_ADDR_W'(joint_index);
			keep    = jnt_ok || last;
			if (jnt_ok && last)
				op.code = OP_TRQ_RUN;
			else if (jnt_ok)
				op.code = OP_TRQ;
			else
				op.code = OP_RUN;
		end
	end

	assign push = start && !q_full && keep;

endmodule

// ===== rtl/jtdw_queue.sv =====
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps
module jtdw_queue import jtdw_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  jtdw_op_t din,
	input  logic     pop,
	output jtdw_op_t dout,
	output logic     empty,
	output logic     full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jtdw_op_t         slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign dout  = slots_q[rd_ptr_q];

	// Store pushed operations
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= din;
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/jtdw_back.sv =====
// Back end: holds the tables, executes writes and computes the drive words.
`timescale 1ns / 1ps
module jtdw_back import jtdw_pkg::*; #(
	parameter int ACTUATORS      = ACTUATORS_DEF,
	parameter int JOINTS         = JOINTS_DEF,
	parameter int DRIVE_CHANNELS = DRIVE_CHANNELS_DEF,
	parameter int DAC_BITS       = DAC_BITS_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  jtdw_op_t    op,
	input  logic        empty,
	output logic        pop,
	output logic        strobe,
	output logic [2:0]  channel,
	output logic [15:0] drive_word,
	output logic        end_of_command
);

	localparam int CPL_N = ACTUATORS * JOINTS;
	localparam int CPL_W = (CPL_N > 1) ? $clog2(CPL_N) : 1;
	localparam int ACT_W = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
	localparam int JNT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int CH_W  = $clog2(DRIVE_CHANNELS);
	localparam int RAW_W = 66;
	localparam logic [RAW_W-1:0] DAC_MAX = (RAW_W'(1) << DAC_BITS) - RAW_W'(1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_ACC  = 4'd3;
	localparam logic [3:0] ST_SAT  = 4'd4;
	localparam logic [3:0] ST_AMP  = 4'd5;
	localparam logic [3:0] ST_CLMP = 4'd6;
	localparam logic [3:0] ST_BIT  = 4'd7;
	localparam logic [3:0] ST_OFS  = 4'd8;
	localparam logic [3:0] ST_EMIT = 4'd9;

	// Tables
	logic [WORD_W-1:0] cpl_mem [CPL_N];
	logic [CPL_N-1:0]  cpl_vld_q;
	logic [WORD_W-1:0] amps_q  [ACTUATORS];
	logic [WORD_W-1:0] lim_q   [ACTUATORS];
	logic [WORD_W-1:0] bsc_q   [ACTUATORS];
	logic [WORD_W-1:0] bof_q   [ACTUATORS];
	logic [WORD_W-1:0] trq_q   [JOINTS];

	// Sequencer and datapath
	logic [3:0]               state_q;
	logic [CH_W-1:0]          chan_q;
	logic [JNT_W-1:0]         jnt_q;
	logic [CPL_W-1:0]         cpl_addr_q;
	logic [WORD_W-1:0]        cpl_rd_q;
	logic                     cpl_rd_vld_q;
	logic [WORD_W-1:0]        trq_rd_q;
	logic signed [63:0]       prod_q;
	logic signed [63:0]       acc_q;
	logic signed [31:0]       tact_q;
	logic signed [32:0]       amps_cl_q;
	logic signed [RAW_W-1:0]  raw_q;
	logic                     strobe_q;
	logic [2:0]               channel_q;
	logic [15:0]              word_q;
	logic                     eoc_q;

	logic [ACT_W-1:0]         act_idx;
	logic                     is_act;
	logic                     last_chan;
	logic                     run;
	logic signed [31:0]       cpl_word;
	logic signed [31:0]       amps_sat;
	logic signed [33:0]       a34;
	logic signed [33:0]       l34;
	logic signed [32:0]       clamped;
	logic [RAW_W-1:0]         whole;
	logic [RAW_W-1:0]         word_full;

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign run       = pop && ((op.code == OP_TRQ_RUN) || (op.code == OP_RUN));
	assign act_idx   = ACT_W'(chan_q);
	assign is_act    = (int'(chan_q) < ACTUATORS);
	assign last_chan = (int'(chan_q) == DRIVE_CHANNELS - 1);
	assign cpl_word  = cpl_rd_vld_q ? $signed(cpl_rd_q) : 32'sd0;

	// Saturate the amps and clamp to the current limit
	always_comb begin
		amps_sat = sat32(prod_q >>> FRAC_BITS);
		a34      = 34'(amps_sat);
		l34      = 34'($signed(lim_q[act_idx]));
		if (a34 >= l34)
			clamped = 33'(l34);
		else if (a34 <= -l34)
			clamped = 33'(-l34);
		else
			clamped = 33'(a34);
	end

	// Truncate toward zero, saturate to the DAC range, and give zero past the actuators
	always_comb begin
		whole = RAW_W'(raw_q) >> (2 * FRAC_BITS);
		if (raw_q[RAW_W-1] || !is_act)
			word_full = '0;
		else if (whole > DAC_MAX)
			word_full = DAC_MAX;
		else
			word_full = whole;
	end

	// Coupling memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (pop && op.code == OP_CPL)
			cpl_mem[op.addr[CPL_W-1:0]] <= op.value;
		if (state_q == ST_RD)
			cpl_rd_q <= cpl_mem[cpl_addr_q];
	end

	// Table writes and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_vld_q    <= '0;
			cpl_rd_vld_q <= 1'b0;
			for (int i = 0; i < ACTUATORS; i++) begin
				amps_q[i] <= '0;
				lim_q[i]  <= '0;
				bsc_q[i]  <= '0;
				bof_q[i]  <= '0;
			end
			for (int i = 0; i < JOINTS; i++)
				trq_q[i] <= '0;
		end else begin
			if (state_q == ST_RD)
				cpl_rd_vld_q <= cpl_vld_q[cpl_addr_q];
			if (pop) begin
				case (op.code)
					OP_CPL:     cpl_vld_q[op.addr[CPL_W-1:0]] <= 1'b1;
					OP_AMPS:    amps_q[op.addr[ACT_W-1:0]] <= op.value;
					OP_LIM:     lim_q[op.addr[ACT_W-1:0]]  <= op.value;
					OP_BSC:     bsc_q[op.addr[ACT_W-1:0]]  <= op.value;
					OP_BOF:     bof_q[op.addr[ACT_W-1:0]]  <= op.value;
					OP_TRQ:     trq_q[op.addr[JNT_W-1:0]]  <= op.value;
					OP_TRQ_RUN: trq_q[op.addr[JNT_W-1:0]]  <= op.value;
					default:    ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD:   trq_rd_q  <= trq_q[jnt_q];
			ST_MUL:  prod_q    <= cpl_word * $signed(trq_rd_q);
			ST_ACC:  acc_q     <= acc_q + (prod_q >>> FRAC_BITS);
			ST_SAT:  tact_q    <= sat32(acc_q);
			ST_AMP:  prod_q    <= tact_q * $signed(amps_q[act_idx]);
			ST_CLMP: amps_cl_q <= clamped;
			ST_BIT:  raw_q     <= RAW_W'(amps_cl_q * $signed(bsc_q[act_idx]));
			ST_OFS:  raw_q     <= raw_q + (RAW_W'($signed(bof_q[act_idx])) <<< FRAC_BITS);
			default: ;
		endcase
		if (run || (state_q == ST_EMIT))
			acc_q <= '0;
		channel_q <= 3'(chan_q);
		word_q    <= word_full[15:0];
	end

	// Sequencer over channels and joints
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chan_q     <= '0;
			jnt_q      <= '0;
			cpl_addr_q <= '0;
			strobe_q   <= 1'b0;
			eoc_q      <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			eoc_q    <= (state_q == ST_EMIT) && last_chan;
			case (state_q)
				ST_IDLE: begin
					if (run) begin
						state_q    <= ST_RD;
						chan_q     <= '0;
						jnt_q      <= '0;
						cpl_addr_q <= '0;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					cpl_addr_q <= cpl_addr_q + 1'b1;
					if (int'(jnt_q) == JOINTS - 1) begin
						jnt_q   <= '0;
						state_q <= ST_SAT;
					end else begin
						jnt_q   <= jnt_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SAT:  state_q <= ST_AMP;
				ST_AMP:  state_q <= ST_CLMP;
				ST_CLMP: state_q <= ST_BIT;
				ST_BIT:  state_q <= ST_OFS;
				ST_OFS:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (last_chan) begin
						state_q <= ST_IDLE;
					end else begin
						chan_q  <= chan_q + 1'b1;
						state_q <= (int'(chan_q) + 1 < ACTUATORS) ? ST_RD : ST_EMIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe         = strobe_q;
	assign channel        = channel_q;
	assign drive_word     = word_q;
	assign end_of_command = eoc_q;

endmodule

// ===== rtl/joint_torque_to_drive_word_top.sv =====
// Top level of the joint torque to drive word converter.
`timescale 1ns / 1ps
// Usage:
// An item is transferred at a rising edge where start is high and busy is low.
// mode 0 items write calibration words; mode 1 items store a joint torque, and
// one marked last launches a command that emits one word per drive channel.
// Items pass through a four-entry queue; busy is high only while it is full.
// A calibration write or plain torque item is executed as the back end pops it.
// A command steps through the actuator channels: each coupling product is read,
// multiplied and accumulated, then the sequencer saturates, scales and clamps
// the amps, applies bits scale and offset, and emits the word; each channel
// past the actuators only emits a zero word. No item is popped meanwhile.
// Results come on strobe with channel, drive_word and end_of_command.
// The receiver cannot stall: each word shows for one cycle.
// Reset zeroes the tables (coupling words by their valid bits), empties the queue and idles the sequencer.
module joint_torque_to_drive_word_top import jtdw_pkg::*; #(
	parameter int ACTUATORS      = ACTUATORS_DEF,
	parameter int JOINTS         = JOINTS_DEF,
	parameter int DRIVE_CHANNELS = DRIVE_CHANNELS_DEF,
	parameter int DAC_BITS       = DAC_BITS_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [2:0]        table_sel,
	input  logic [2:0]        actuator_index,
	input  logic [2:0]        joint_index,
	input  logic [WORD_W-1:0] value,
	input  logic              last,
	output logic              strobe,
	output logic [2:0]        channel,
	output logic [15:0]       drive_word,
	output logic              end_of_command
);

`include "joint_torque_to_drive_word_top_defines.svh"

	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;
	jtdw_op_t op_in;
	jtdw_op_t op_out;

	assign busy = q_full;

	jtdw_front #(
		.ACTUATORS (ACTUATORS),
		.JOINTS    (JOINTS)
	) u_front (
		.start          (start),
		.q_full         (q_full),
		.mode           (mode),
		.table_sel      (table_sel),
		.actuator_index (actuator_index),
		.joint_index    (joint_index),
		.value          (value),
		.last           (last),
		.push           (push),
		.op             (op_in)
	);

	jtdw_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (op_in),
		.pop    (pop),
		.dout   (op_out),
		.empty  (q_empty),
		.full   (q_full)
	);

	jtdw_back #(
		.ACTUATORS      (ACTUATORS),
		.JOINTS         (JOINTS),
		.DRIVE_CHANNELS (DRIVE_CHANNELS),
		.DAC_BITS       (DAC_BITS),
		.FRAC_BITS      (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op_out),
		.empty          (q_empty),
		.pop            (pop),
		.strobe         (strobe),
		.channel        (channel),
		.drive_word     (drive_word),
		.end_of_command (end_of_command)
	);

	// Check result sequencing
	`JTDW_ASSERT_SAME(a_eoc_strobe, end_of_command, strobe, "end_of_command without strobe")
	`JTDW_ASSERT_NEXT(a_eoc_gap, strobe && end_of_command, !strobe, "word right after command end")
	`JTDW_ASSERT_SAME(a_chan_step, strobe && $past(strobe), channel == 3'($past(channel) + 3'd1), "channel skipped")

endmodule

// ===== tb/joint_torque_to_drive_word_top_test.sv =====
// Self-checking testbench of the joint torque to drive word converter.
`timescale 1ns / 1ps
module joint_torque_to_drive_word_top_test;
	import jtdw_pkg::*;

	localparam int N_ACT      = ACTUATORS_DEF;
	localparam int N_JNT      = JOINTS_DEF;
	localparam int N_CHAN     = DRIVE_CHANNELS_DEF;
	localparam int N_RANDOM   = 410;
	localparam int DRAIN_WAIT = 200;
	localparam int CYCLE_CAP  = 400000;

	typedef struct {
		logic [2:0]  channel;
		logic [15:0] drive_word;
		logic        end_of_command;
	} drive_result_t;

	typedef struct {
		logic        mode;
		logic [2:0]  table_sel;
		logic [2:0]  actuator_index;
		logic [2:0]  joint_index;
		logic [31:0] value;
		logic        last;
		bit          typed;     // channel 0 word typed in below
		logic [15:0] word0;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [2:0]  table_sel;
	logic [2:0]  actuator_index;
	logic [2:0]  joint_index;
	logic [31:0] value;
	logic        last;
	logic        strobe;
	logic [2:0]  channel;
	logic [15:0] drive_word;
	logic        end_of_command;

	// Calibration tables and torque vector held by the predictor
	int coupling[N_ACT][N_JNT];
	int amps_scale[N_ACT];
	int amps_limit[N_ACT];
	int bits_scale[N_ACT];
	int bits_offset[N_ACT];
	int joint_torque[N_JNT];

	drive_result_t pending_words[$];
	int            n_fail;
	int            n_cycles;

	joint_torque_to_drive_word_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.table_sel      (table_sel),
		.actuator_index (actuator_index),
		.joint_index    (joint_index),
		.value          (value),
		.last           (last),
		.strobe         (strobe),
		.channel        (channel),
		.drive_word     (drive_word),
		.end_of_command (end_of_command)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clamp_s32(input longint v);
		if (v > longint'(32'sh7fff_ffff))
			return longint'(32'sh7fff_ffff);
		if (v < -longint'(64'sh8000_0000))
			return -longint'(64'sh8000_0000);
		return v;
	endfunction

	// Compute one actuator's DAC word from the held tables
	function automatic logic [15:0] actuator_drive_word(input int a);
		longint sum;
		longint amps;
		longint lim;
		longint raw;
		longint whole;
		sum = 0;
		for (int j = 0; j < N_JNT; j++)
			sum += (longint'(coupling[a][j]) * longint'(joint_torque[j])) >>> FRAC_BITS_DEF;
		amps = clamp_s32((clamp_s32(sum) * longint'(amps_scale[a])) >>> FRAC_BITS_DEF);
		lim = longint'(amps_limit[a]);
		if (amps >= lim)
			amps = lim;
		else if (amps <= -lim)
			amps = -lim;
		raw = amps * longint'(bits_scale[a]) + (longint'(bits_offset[a]) <<< FRAC_BITS_DEF);
		whole = raw / (longint'(1) <<< (2 * FRAC_BITS_DEF));
		if (whole < 0)
			whole = 0;
		if (whole > 65535)
			whole = 65535;
		return whole[15:0];
	endfunction

	// Update the held state for one transfer and queue the words it causes
	function automatic void predict_drive_words(input stim_row_t r);
		drive_result_t w;
		int v;
		v = int'(r.value);
		if (r.mode == 1'b0) begin
			if (r.actuator_index >= N_ACT)
				return;
			case (r.table_sel)
				SEL_CPL: if (r.joint_index < N_JNT)
					coupling[r.actuator_index][r.joint_index] = v;
				SEL_AMPS: amps_scale[r.actuator_index] = v;
				SEL_LIM:  amps_limit[r.actuator_index] = v;
				SEL_BSC:  bits_scale[r.actuator_index] = v;
				SEL_BOF:  bits_offset[r.actuator_index] = v;
				default: ;
			endcase
			return;
		end
		if (r.joint_index < N_JNT)
			joint_torque[r.joint_index] = v;
		if (!r.last)
			return;
		for (int c = 0; c < N_CHAN; c++) begin
			w.channel = c[2:0];
			w.drive_word = (c < N_ACT) ? actuator_drive_word(c) : 16'd0;
			if (c == 0 && r.typed)
				w.drive_word = r.word0;
			w.end_of_command = (c == N_CHAN - 1);
			pending_words.push_back(w);
		end
	endfunction

	// Present one item after its gap and hold it until the transfer
	task automatic send_item(input stim_row_t r);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		mode           <= r.mode;
		table_sel      <= r.table_sel;
		actuator_index <= r.actuator_index;
		joint_index    <= r.joint_index;
		value          <= r.value;
		last           <= r.last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_drive_words(r);
	endtask

	function automatic logic [31:0] draw_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 32'h0003_ffff));
			3: return -32'($urandom_range(0, 32'h0003_ffff));
			4: return 32'($urandom_range(0, 32'h0fff_ffff));
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed writes and torque vectors, some noise
	function automatic stim_row_t draw_item();
		stim_row_t r;
		int kind;
		kind = $urandom_range(0, 99);
		r.typed = 1'b0;
		r.word0 = '0;
		r.value = draw_value();
		r.last  = 1'($urandom);
		if (kind < 40) begin
			r.mode           = 1'b0;
			r.table_sel      = 3'($urandom_range(0, 4));
			r.actuator_index = 3'($urandom_range(0, N_ACT - 1));
			r.joint_index    = 3'($urandom_range(0, N_JNT - 1));
		end else if (kind < 85) begin
			r.mode           = 1'b1;
			r.table_sel      = 3'($urandom);
			r.actuator_index = 3'($urandom);
			r.joint_index    = 3'($urandom_range(0, N_JNT - 1));
			r.last           = ($urandom_range(0, 5) == 0);
		end else begin
			r.mode           = 1'($urandom);
			r.table_sel      = 3'($urandom);
			r.actuator_index = 3'($urandom);
			r.joint_index    = 3'($urandom);
		end
		return r;
	endfunction

	// Directed rows: reset state, extremes, ignored writes, out-of-range torque
	stim_row_t directed_rows[] = '{
		'{1'b1, 3'd0,     3'd0, 3'd0, 32'h0001_0000, 1'b1, 1'b1, 16'd0},
		'{1'b0, SEL_CPL,  3'd0, 3'd0, 32'h0001_0000, 1'b0, 1'b0, 16'd0},
		'{1'b0, SEL_AMPS, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 1'b0, 16'd0},
		'{1'b0, SEL_LIM,  3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 1'b0, 16'd0},
		'{1'b0, SEL_BOF,  3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd0, 32'h7fff_ffff, 1'b1, 1'b1, 16'd32767},
		'{1'b0, SEL_BSC,  3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd0, 32'h7fff_ffff, 1'b1, 1'b1, 16'd65535},
		'{1'b0, SEL_BOF,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b1, 16'd0},
		'{1'b0, SEL_BOF,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 16'd0},
		'{1'b0, SEL_LIM,  3'd0, 3'd0, 32'hffff_0000, 1'b0, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd1, 32'h0000_0000, 1'b1, 1'b0, 16'd0},
		'{1'b0, 3'd5,     3'd1, 3'd0, 32'h0001_0000, 1'b0, 1'b0, 16'd0},
		'{1'b0, 3'd7,     3'd1, 3'd0, 32'h0001_0000, 1'b1, 1'b0, 16'd0},
		'{1'b0, SEL_AMPS, 3'd7, 3'd0, 32'h0001_0000, 1'b0, 1'b0, 16'd0},
		'{1'b0, SEL_CPL,  3'd1, 3'd6, 32'h0001_0000, 1'b0, 1'b0, 16'd0},
		'{1'b0, SEL_CPL,  3'd1, 3'd7, 32'h0002_0000, 1'b1, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd7, 32'h1234_5678, 1'b0, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd6, 32'h0001_0000, 1'b1, 1'b0, 16'd0},
		'{1'b1, 3'd0,     3'd0, 3'd5, 32'hffff_ffff, 1'b0, 1'b0, 16'd0},
		'{1'b1, 3'd7,     3'd7, 3'd5, 32'h0000_8000, 1'b1, 1'b0, 16'd0}
	};

	// Check every strobed word against the oldest expectation
	always @(posedge clk) begin
		drive_result_t w;
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: channel %0d drive_word %0d", channel, drive_word);
				n_fail++;
			end else begin
				w = pending_words.pop_front();
				if (channel !== w.channel) begin
					$error("channel: expected %0d, actual %0d", w.channel, channel);
					n_fail++;
				end
				if (drive_word !== w.drive_word) begin
					$error("drive_word: expected %0d, actual %0d", w.drive_word, drive_word);
					n_fail++;
				end
				if (end_of_command !== w.end_of_command) begin
					$error("end_of_command: expected %0b, actual %0b",
						w.end_of_command, end_of_command);
					n_fail++;
				end
			end
		end
	end

	// End the run if it hangs
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		n_fail   = 0;
		n_cycles = 0;
		foreach (coupling[a, j])
			coupling[a][j] = 0;
		for (int a = 0; a < N_ACT; a++) begin
			amps_scale[a]  = 0;
			amps_limit[a]  = 0;
			bits_scale[a]  = 0;
			bits_offset[a] = 0;
		end
		foreach (joint_torque[j])
			joint_torque[j] = 0;
		arst_n         <= 1'b0;
		start          <= 1'b0;
		mode           <= 1'b0;
		table_sel      <= '0;
		actuator_index <= '0;
		joint_index    <= '0;
		value          <= '0;
		last           <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);
		for (int i = 0; i < N_RANDOM; i++)
			send_item(draw_item());
		start <= 1'b0;

		// Drain outstanding words, then watch for strays
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jtdw_pkg.sv
rtl/jtdw_front.sv
rtl/jtdw_queue.sv
rtl/jtdw_back.sv
rtl/joint_torque_to_drive_word_top.sv
tb/joint_torque_to_drive_word_top_test.sv
